@@ hdl/bcv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcv_pkg
// Shared types, constants and control structs of the bridge/cut-vertex finder.
// ----------------------------------------------------------------------------
package bcv_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 32;
  localparam int unsigned MAX_EDGES_DEF    = 64;
  localparam int unsigned VCNT_W           = 6;   // vertex_count register width
  localparam int unsigned TIME_W           = 6;   // discovery / low time width

  typedef enum logic [1:0] {
    KIND_BRIDGE = 2'd0,
    KIND_CUT    = 2'd1,
    KIND_DONE   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [4:0] end_a;
    logic [4:0] end_b;
    logic       last_edge;
  } in_t;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] vertex_a;
    logic [4:0] vertex_b;
    logic       dropped;
    logic       last;
  } out_t;

  typedef enum logic [9:0] {
    ST_LOAD  = 10'b00_0000_0001,
    ST_OUTER = 10'b00_0000_0010,
    ST_SCAN  = 10'b00_0000_0100,
    ST_EDGE  = 10'b00_0000_1000,
    ST_BACK  = 10'b00_0001_0000,
    ST_PUSH  = 10'b00_0010_0000,
    ST_POP   = 10'b00_0100_0000,
    ST_POP2  = 10'b00_1000_0000,
    ST_CUTS  = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic load;
    logic start_search;
    logic outer_skip;
    logic start_root;
    logic cuts_init;
    logic scan_issue;
    logic latch_w;
    logic read_w;
    logic push;
    logic back;
    logic pop;
    logic pop_last;
    logic pop_finish;
    logic cut_step;
    logic done_emit;
  } cmd_t;

  typedef struct packed {
    logic in_last;
    logic sv_done;
    logic sv_vis;
    logic scan_end;
    logic found;
    logic w_vis;
    logic last_pop;
    logic bridge_hit;
    logic out_free;
    logic cv_done;
    logic cut_hit;
  } sts_t;

endpackage

@@ hdl/bridge_and_cut_vertex_finder.sv @@
`timescale 1ns / 1ps
// Operation: edges load one per cycle; after the final edge the search runs the outer
//   sweep, scans the stored edges of each vertex, visits each neighbor found, retires
//   each vertex, then sweeps the vertices for cut vertices and emits done.
// Throughput: one edge transaction per cycle while loading; input stalls for the
//   whole search, and each result waits for a free output register.
// Reset: asynchronous, active low; clears control and graph flags, vertex_count=32.
// ----------------------------------------------------------------------------
// bridge_and_cut_vertex_finder
// Finds bridges and articulation points of a loaded undirected graph.
// ----------------------------------------------------------------------------
module bridge_and_cut_vertex_finder #(
  parameter int unsigned MaxVertices = bcv_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MaxEdges    = bcv_pkg::MAX_EDGES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // edge transactions
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  bcv_pkg::in_t               in_data_i,
  // result transactions
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output bcv_pkg::out_t              out_data_o,
  // vertex_count register write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bcv_pkg::VCNT_W-1:0] cfg_data_i
);

  bcv_pkg::cmd_t cmd;
  bcv_pkg::sts_t sts;

  // Register is taken only while edges are loading, never mid-search.
  assign cfg_ready_o = !in_stall_o;

  // Sequencer: walks the graph one step per state, driven by datapath flags.
  bcv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: edge store, per-vertex tables, stack and output register.
  bcv_dpath #(
    .MaxVertices (MaxVertices),
    .MaxEdges    (MaxEdges)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`ifndef SYNTHESIS
  // The final edge starts the search; no edge is taken in the next cycle.
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.last_edge) |=> in_stall_o)
    else $error("edge accepted right after the final edge");

  // Only the done transaction carries last.
  a_last_is_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.last) |-> (out_data_o.kind == bcv_pkg::KIND_DONE))
    else $error("last set on a non-done transaction");

  // Bridges and cut vertices carry no drop or last flag.
  a_plain_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind != bcv_pkg::KIND_DONE) |->
      (!out_data_o.dropped && !out_data_o.last))
    else $error("flags set on a bridge or cut transaction");
`endif

endmodule

@@ hdl/bcv_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/bcv_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcv_ctrl
// Sequencer: load, depth-first walk, cut-vertex sweep and done transaction.
// ----------------------------------------------------------------------------
module bcv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bcv_pkg::sts_t sts_i,
  output bcv_pkg::cmd_t cmd_o
);

  bcv_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      bcv_pkg::ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.in_last) begin
            cmd_o.start_search = 1'b1;
            state_d = bcv_pkg::ST_OUTER;
          end
        end
      end
      bcv_pkg::ST_OUTER: begin
        if (sts_i.sv_done) begin
          cmd_o.cuts_init = 1'b1;
          state_d = bcv_pkg::ST_CUTS;
        end else if (sts_i.sv_vis) begin
          cmd_o.outer_skip = 1'b1;
        end else begin
          cmd_o.start_root = 1'b1;
          state_d = bcv_pkg::ST_SCAN;
        end
      end
      bcv_pkg::ST_SCAN: begin
        if (sts_i.scan_end) begin
          state_d = bcv_pkg::ST_POP;
        end else begin
          cmd_o.scan_issue = 1'b1;
          state_d = bcv_pkg::ST_EDGE;
        end
      end
      bcv_pkg::ST_EDGE: begin
        if (sts_i.found) begin
          cmd_o.latch_w = 1'b1;
          if (sts_i.w_vis) begin
            cmd_o.read_w = 1'b1;
            state_d = bcv_pkg::ST_BACK;
          end else begin
            state_d = bcv_pkg::ST_PUSH;
          end
        end else begin
          state_d = bcv_pkg::ST_SCAN;
        end
      end
      bcv_pkg::ST_BACK: begin
        cmd_o.back = 1'b1;
        state_d = bcv_pkg::ST_SCAN;
      end
      bcv_pkg::ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d = bcv_pkg::ST_SCAN;
      end
      bcv_pkg::ST_POP: begin
        cmd_o.pop = 1'b1;
        if (sts_i.last_pop) begin
          cmd_o.pop_last = 1'b1;
          state_d = bcv_pkg::ST_OUTER;
        end else begin
          state_d = bcv_pkg::ST_POP2;
        end
      end
      bcv_pkg::ST_POP2: begin
        if (!sts_i.bridge_hit || sts_i.out_free) begin
          cmd_o.pop_finish = 1'b1;
          state_d = bcv_pkg::ST_SCAN;
        end
      end
      bcv_pkg::ST_CUTS: begin
        if (sts_i.cv_done) begin
          state_d = bcv_pkg::ST_DONE;
        end else if (!sts_i.cut_hit || sts_i.out_free) begin
          cmd_o.cut_step = 1'b1;
        end
      end
      bcv_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.done_emit = 1'b1;
          state_d = bcv_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = bcv_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcv_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != bcv_pkg::ST_LOAD);

endmodule

@@ hdl/bcv_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcv_dpath
// Edge store, per-vertex tables, walk stack, counters and output register.
// ----------------------------------------------------------------------------
module bcv_dpath #(
  parameter int unsigned MaxVertices = bcv_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MaxEdges    = bcv_pkg::MAX_EDGES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bcv_pkg::in_t                in_data_i,
  input  logic                        cfg_valid_i,
  input  logic [bcv_pkg::VCNT_W-1:0]  cfg_data_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output bcv_pkg::out_t               out_data_o,
  input  bcv_pkg::cmd_t               cmd_i,
  output bcv_pkg::sts_t               sts_o
);

  localparam int unsigned VA  = $clog2(MaxVertices);
  localparam int unsigned DW  = $clog2(MaxVertices + 1);
  localparam int unsigned EA  = (MaxEdges > 1) ? $clog2(MaxEdges) : 1;
  localparam int unsigned ECW = $clog2(MaxEdges + 1);
  localparam int unsigned CW  = bcv_pkg::VCNT_W;
  localparam int unsigned TW  = bcv_pkg::TIME_W;

  // configuration and counters
  logic [CW-1:0]  vc_q;
  logic [ECW-1:0] etot_q;
  logic           drop_q;
  logic [TW-1:0]  time_q;
  logic [CW-1:0]  sv_q, cv_q;
  logic [DW-1:0]  depth_q;
  logic [1:0]     rc_q;
  logic [VA-1:0]  root_q, cur_v_q, cur_par_q, w_q, ch_v_q;
  logic [ECW-1:0] cur_i_q;
  logic [TW-1:0]  cur_low_q, ch_low_q;
  logic [MaxVertices-1:0] vis_q, cut_q;
  logic           out_valid_q;
  bcv_pkg::out_t  out_q;

  logic [CW-1:0]  nv;
  logic           in_ok;
  logic [TW-1:0]  t_next;
  logic [2*VA-1:0] e_rd;
  logic [VA-1:0]  ea, eb, w_c;
  logic           out_free;

  // RAM ports
  logic           disc_we, low_we, par_we, disc_re, pop_re;
  logic [VA-1:0]  disc_wa, low_wa, disc_ra;
  logic [TW-1:0]  disc_wd, low_wd, disc_rd, low_rd;
  logic [VA-1:0]  par_wd, par_rd;
  logic [ECW-1:0] stk_rd;
  logic [TW-1:0]  new_low;
  logic           bridge, cut_set;

  assign nv     = (vc_q > CW'(MaxVertices)) ? CW'(MaxVertices) : vc_q;
  assign in_ok  = ({1'b0, in_data_i.end_a} < nv) &&
                  ({1'b0, in_data_i.end_b} < nv) &&
                  (etot_q < ECW'(MaxEdges));
  assign t_next = time_q + TW'(1);
  assign ea     = e_rd[2*VA-1:VA];
  assign eb     = e_rd[VA-1:0];
  assign w_c    = (ea == cur_v_q) ? eb : ea;
  assign out_free = !out_valid_q || !out_stall_i;

  assign new_low = (ch_low_q < low_rd) ? ch_low_q : low_rd;
  assign bridge  = ch_low_q > disc_rd;
  assign cut_set = (cur_par_q != root_q) && (ch_low_q >= disc_rd);

  always_comb begin
    sts_o            = '0;
    sts_o.in_last    = in_data_i.last_edge;
    sts_o.sv_done    = sv_q >= nv;
    sts_o.sv_vis     = vis_q[sv_q[VA-1:0]];
    sts_o.scan_end   = cur_i_q >= etot_q;
    sts_o.found      = (ea == cur_v_q) || (eb == cur_v_q);
    sts_o.w_vis      = vis_q[w_c];
    sts_o.last_pop   = depth_q == DW'(1);
    sts_o.bridge_hit = bridge;
    sts_o.out_free   = out_free;
    sts_o.cv_done    = cv_q >= nv;
    sts_o.cut_hit    = cut_q[cv_q[VA-1:0]];
  end

  // table write/read muxing
  always_comb begin
    disc_we = cmd_i.start_root || cmd_i.push;
    par_we  = disc_we;
    disc_wa = cmd_i.push ? w_q : sv_q[VA-1:0];
    disc_wd = t_next;
    par_wd  = cmd_i.push ? cur_v_q : sv_q[VA-1:0];
    low_we  = disc_we || (cmd_i.back && (disc_rd < cur_low_q) &&
              ((cur_v_q == root_q) || (w_q != cur_par_q))) || cmd_i.pop_finish;
    low_wa  = disc_wa;
    low_wd  = t_next;
    if (cmd_i.back) begin
      low_wa = cur_v_q;
      low_wd = disc_rd;
    end else if (cmd_i.pop_finish) begin
      low_wa = cur_par_q;
      low_wd = new_low;
    end
    pop_re  = cmd_i.pop && !cmd_i.pop_last;
    disc_re = cmd_i.read_w || pop_re;
    disc_ra = cmd_i.read_w ? w_c : cur_par_q;
  end

  bcv_ram #(.Width(2*VA), .Depth(MaxEdges)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load && in_ok),
    .waddr_i (etot_q[EA-1:0]),
    .wdata_i ({in_data_i.end_a[VA-1:0], in_data_i.end_b[VA-1:0]}),
    .re_i    (cmd_i.scan_issue),
    .raddr_i (cur_i_q[EA-1:0]),
    .rdata_o (e_rd)
  );

  bcv_ram #(.Width(TW), .Depth(MaxVertices)) u_disc_ram (
    .clk_i   (clk_i),
    .we_i    (disc_we),
    .waddr_i (disc_wa),
    .wdata_i (disc_wd),
    .re_i    (disc_re),
    .raddr_i (disc_ra),
    .rdata_o (disc_rd)
  );

  bcv_ram #(.Width(TW), .Depth(MaxVertices)) u_low_ram (
    .clk_i   (clk_i),
    .we_i    (low_we),
    .waddr_i (low_wa),
    .wdata_i (low_wd),
    .re_i    (pop_re),
    .raddr_i (cur_par_q),
    .rdata_o (low_rd)
  );

  bcv_ram #(.Width(VA), .Depth(MaxVertices)) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (disc_wa),
    .wdata_i (par_wd),
    .re_i    (pop_re),
    .raddr_i (cur_par_q),
    .rdata_o (par_rd)
  );

  // walk stack: edge scan position of each vertex on the current path
  bcv_ram #(.Width(ECW), .Depth(MaxVertices)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (VA'(depth_q - DW'(1))),
    .wdata_i (cur_i_q),
    .re_i    (pop_re),
    .raddr_i (VA'(depth_q - DW'(2))),
    .rdata_o (stk_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q        <= CW'(MaxVertices);
      etot_q      <= '0;
      drop_q      <= 1'b0;
      time_q      <= '0;
      sv_q        <= '0;
      cv_q        <= '0;
      depth_q     <= '0;
      rc_q        <= '0;
      root_q      <= '0;
      vis_q       <= '0;
      cut_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        vc_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        if (in_ok) begin
          etot_q <= etot_q + ECW'(1);
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (cmd_i.start_search || cmd_i.outer_skip) begin
        sv_q <= cmd_i.start_search ? '0 : sv_q + CW'(1);
      end
      if (cmd_i.start_root) begin
        root_q             <= sv_q[VA-1:0];
        rc_q               <= '0;
        time_q             <= t_next;
        vis_q[sv_q[VA-1:0]] <= 1'b1;
        depth_q            <= DW'(1);
      end
      if (cmd_i.push) begin
        if (cur_v_q == root_q && rc_q != 2'd2) begin
          rc_q <= rc_q + 2'd1;
        end
        time_q     <= t_next;
        vis_q[w_q] <= 1'b1;
        depth_q    <= depth_q + DW'(1);
      end
      if (cmd_i.pop) begin
        depth_q <= depth_q - DW'(1);
        if (cmd_i.pop_last) begin
          cut_q[root_q] <= rc_q == 2'd2;
        end
      end
      if (cmd_i.pop_finish && cut_set) begin
        cut_q[cur_par_q] <= 1'b1;
      end
      if (cmd_i.cuts_init) begin
        cv_q <= '0;
      end else if (cmd_i.cut_step) begin
        cv_q <= cv_q + CW'(1);
      end
      if (cmd_i.done_emit) begin
        etot_q <= '0;
        drop_q <= 1'b0;
        time_q <= '0;
        vis_q  <= '0;
        cut_q  <= '0;
      end
      if ((cmd_i.pop_finish && bridge) || (cmd_i.cut_step && sts_o.cut_hit) ||
          cmd_i.done_emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // walk registers and output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_root) begin
      cur_v_q   <= sv_q[VA-1:0];
      cur_par_q <= sv_q[VA-1:0];
      cur_i_q   <= '0;
      cur_low_q <= t_next;
    end
    if (cmd_i.scan_issue) begin
      cur_i_q <= cur_i_q + ECW'(1);
    end
    if (cmd_i.latch_w) begin
      w_q <= w_c;
    end
    if (cmd_i.back && (disc_rd < cur_low_q) &&
        ((cur_v_q == root_q) || (w_q != cur_par_q))) begin
      cur_low_q <= disc_rd;
    end
    if (cmd_i.push) begin
      cur_par_q <= cur_v_q;
      cur_v_q   <= w_q;
      cur_i_q   <= '0;
      cur_low_q <= t_next;
    end
    if (pop_re) begin
      ch_v_q   <= cur_v_q;
      ch_low_q <= cur_low_q;
    end
    if (cmd_i.pop_finish) begin
      cur_v_q   <= cur_par_q;
      cur_par_q <= par_rd;
      cur_i_q   <= stk_rd;
      cur_low_q <= new_low;
    end
    if (cmd_i.pop_finish && bridge) begin
      out_q <= '{kind: bcv_pkg::KIND_BRIDGE, vertex_a: 5'(cur_par_q),
                 vertex_b: 5'(ch_v_q), dropped: 1'b0, last: 1'b0};
    end else if (cmd_i.cut_step && sts_o.cut_hit) begin
      out_q <= '{kind: bcv_pkg::KIND_CUT, vertex_a: 5'(cv_q),
                 vertex_b: 5'd0, dropped: 1'b0, last: 1'b0};
    end else if (cmd_i.done_emit) begin
      out_q <= '{kind: bcv_pkg::KIND_DONE, vertex_a: 5'd0,
                 vertex_b: 5'd0, dropped: drop_q, last: 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bridge/cut-vertex finder: graphs of edge
// transactions go in, bridges, cut vertices and the done marker come out and
// are checked in order against an in-bench depth-first-search predictor.
// ----------------------------------------------------------------------------
module tb;

  localparam int NV_MAX = 32;
  localparam int NE_MAX = 64;
  localparam int WATCHDOG = 200000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  bcv_pkg::in_t in_data_i;
  logic out_valid_o, out_stall_i;
  bcv_pkg::out_t out_data_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [bcv_pkg::VCNT_W-1:0] cfg_data_i;

  bridge_and_cut_vertex_finder i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the graph store and search state.
  // ---------------------------------------------------------------------------
  int unsigned vcount;
  int unsigned ea [NE_MAX];
  int unsigned eb [NE_MAX];
  int unsigned n_edges;
  int unsigned disc [NV_MAX];
  int unsigned lowv [NV_MAX];
  int unsigned par [NV_MAX];
  bit cut [NV_MAX];
  int unsigned stk_v [NV_MAX];
  int unsigned stk_i [NV_MAX];
  int unsigned sp, tick, root_n;
  bit lost;
  bcv_pkg::out_t expected_q[$];
  bcv_pkg::out_t last_seen;
  int errors;

  function automatic bcv_pkg::out_t mk(bcv_pkg::kind_e k, int unsigned a,
                                       int unsigned b, bit d, bit l);
    bcv_pkg::out_t r;
    r.kind = k; r.vertex_a = a[4:0]; r.vertex_b = b[4:0]; r.dropped = d; r.last = l;
    return r;
  endfunction

  function automatic void add_expect(bcv_pkg::out_t e);
    expected_q = {expected_q, e};
  endfunction

  function automatic void wipe_graph();
    n_edges = 0; sp = 0; tick = 0; root_n = 0; lost = 1'b0;
    for (int i = 0; i < NV_MAX; i++) begin
      disc[i] = 0; lowv[i] = 0; par[i] = 0; cut[i] = 1'b0;
    end
  endfunction

  function automatic void discover(int unsigned v, int unsigned p);
    tick++;
    disc[v] = tick; lowv[v] = tick; par[v] = p;
    if (sp < NV_MAX) begin
      stk_v[sp] = v; stk_i[sp] = 0; sp++;
    end
  endfunction

  // Iterative DFS from one root; bridges go straight to the expectation queue.
  function automatic void walk_from(int unsigned root);
    int unsigned v, i, w, p;
    bit hit;
    root_n = 0;
    discover(root, root);
    while (sp > 0) begin
      v = stk_v[sp-1]; i = stk_i[sp-1]; w = 0; hit = 1'b0;
      while (i < n_edges && !hit) begin
        if (ea[i] == v) begin w = eb[i]; hit = 1'b1; end
        else if (eb[i] == v) begin w = ea[i]; hit = 1'b1; end
        i++;
      end
      stk_i[sp-1] = i;
      if (hit) begin
        if (disc[w] == 0) begin
          if (v == root) root_n++;
          discover(w, v);
        end else if (v == root || w != par[v]) begin
          if (disc[w] < lowv[v]) lowv[v] = disc[w];
        end
      end else begin
        sp--;
        if (sp > 0) begin
          p = par[v] % NV_MAX;
          if (lowv[v] < lowv[p]) lowv[p] = lowv[v];
          if (lowv[v] > disc[p]) add_expect(mk(bcv_pkg::KIND_BRIDGE, p, v, 1'b0, 1'b0));
          if (p != root && lowv[v] >= disc[p]) cut[p] = 1'b1;
        end
      end
    end
    cut[root] = (root_n >= 2);
  endfunction

  // One edge transaction; on the last edge the whole result list is queued.
  function automatic void predict_edge(bcv_pkg::in_t it);
    int unsigned nv, a, b;
    nv = (vcount > NV_MAX) ? NV_MAX : vcount;
    a = 32'(it.end_a);
    b = 32'(it.end_b);
    if (a >= nv || b >= nv || n_edges >= NE_MAX) lost = 1'b1;
    else begin
      ea[n_edges] = a; eb[n_edges] = b; n_edges++;
    end
    if (!it.last_edge) return;
    for (int unsigned v = 0; v < nv; v++) if (disc[v] == 0) walk_from(v);
    for (int unsigned v = 0; v < nv; v++)
      if (cut[v]) add_expect(mk(bcv_pkg::KIND_CUT, v, 0, 1'b0, 1'b0));
    add_expect(mk(bcv_pkg::KIND_DONE, 0, 0, lost, 1'b1));
    wipe_graph();
  endfunction

  task automatic report_mismatch(string what, bcv_pkg::out_t got, bcv_pkg::out_t exp);
    $display("MISMATCH %s: got k=%0d a=%0d b=%0d d=%0b l=%0b exp k=%0d a=%0d b=%0d d=%0b l=%0b",
             what, got.kind, got.vertex_a, got.vertex_b, got.dropped, got.last,
             exp.kind, exp.vertex_a, exp.vertex_b, exp.dropped, exp.last);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Idle rates, watchdog and result checking (sampled at the rising edge).
  // ---------------------------------------------------------------------------
  int unsigned src_idle_pct, snk_idle_pct;
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        last_seen <= out_data_o;
        if (expected_q.size() == 0) report_mismatch("unexpected", out_data_o, '0);
        else begin
          bcv_pkg::out_t e;
          e = expected_q.pop_front();
          if (out_data_o.kind !== e.kind || out_data_o.vertex_a !== e.vertex_a ||
              out_data_o.vertex_b !== e.vertex_b || out_data_o.dropped !== e.dropped ||
              out_data_o.last !== e.last)
            report_mismatch("field", out_data_o, e);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < snk_idle_pct);
  end

  initial begin
    @(posedge clk_i);
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (quiet_cycles >= WATCHDOG) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Send one edge transaction: drive at the falling edge, hold through stalls.
  // Valid stays up afterwards; the next edge or drain() takes it over.
  task automatic send_edge(bcv_pkg::in_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_edge(it);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_vcount(logic [bcv_pkg::VCNT_W-1:0] val);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    vcount = 32'(val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every result, then compare the last one with a pinned done.
  task automatic check_done(bcv_pkg::out_t exp);
    drain();
    if (last_seen !== exp) report_mismatch("pinned done", last_seen, exp);
  endtask

  // Directed rows: vertex_count (0 keeps current), edge, and an optional
  // pinned done transaction checked directly against the block's output.
  typedef struct {
    int unsigned vc;
    bcv_pkg::in_t item;
    bit typed;
    bcv_pkg::out_t exp_done;
  } row_t;

  row_t rows[$];

  task automatic add_row(int unsigned vc, int unsigned a, int unsigned b, bit l);
    row_t r;
    r.vc = vc; r.item.end_a = 5'(a); r.item.end_b = 5'(b); r.item.last_edge = l;
    r.typed = 1'b0; r.exp_done = '0;
    rows = {rows, r};
  endtask

  task automatic pin_done(bit d);
    rows[rows.size()-1].typed = 1'b1;
    rows[rows.size()-1].exp_done = mk(bcv_pkg::KIND_DONE, 0, 0, d, 1'b1);
  endtask

  // Random graph: mostly valid edges on a small vertex set, some noise.
  task automatic random_graph(int unsigned nv, int unsigned n);
    bcv_pkg::in_t it;
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(15) == 0) begin
        it.end_a = 5'($urandom); it.end_b = 5'($urandom);
      end else begin
        it.end_a = 5'($urandom_range(nv - 1)); it.end_b = 5'($urandom_range(nv - 1));
      end
      it.last_edge = (k == n - 1);
      send_edge(it);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned nv;
    int unsigned n;
    errors = 0; quiet_cycles = 0;
    in_valid_i = 1'b0; in_data_i = '0; cfg_valid_i = 1'b0; cfg_data_i = '0;
    out_stall_i = 1'b0; src_idle_pct = 24; snk_idle_pct = 59;
    last_seen = '0;
    rst_ni = 1'b0;
    vcount = NV_MAX;
    wipe_graph();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset state, path with bridges, triangle, parallel edge to
    // parent, self loop, non-root cut vertex, bad endpoints, overflow.
    add_row(0, 0, 0, 1); pin_done(1'b0);                            // self loop, done only
    add_row(0, 0, 1, 0); add_row(0, 1, 2, 0); add_row(0, 2, 3, 1);  // path
    add_row(4, 0, 1, 0); add_row(0, 1, 2, 0); add_row(0, 2, 0, 0);
    add_row(0, 2, 3, 0); add_row(0, 3, 3, 1);                       // triangle+tail
    add_row(3, 0, 1, 0); add_row(0, 1, 0, 0); add_row(0, 1, 2, 1);  // parallel
    add_row(5, 2, 0, 0); add_row(0, 2, 4, 0); add_row(0, 7, 1, 1);  // non-root cut, bad
    add_row(1, 0, 0, 0); add_row(0, 0, 1, 1);                       // one vertex
    add_row(63, 31, 30, 0); add_row(0, 31, 31, 1); pin_done(1'b0);  // clipped to 32
    add_row(32, 0, 31, 1);
    foreach (rows[k]) begin
      if (rows[k].vc != 0) write_vcount(rows[k].vc[bcv_pkg::VCNT_W-1:0]);
      send_edge(rows[k].item);
      if (rows[k].typed) check_done(rows[k].exp_done);
    end
    write_vcount(0);                     // every edge dropped
    send_edge('{end_a: 5'd0, end_b: 5'd0, last_edge: 1'b1});
    check_done(mk(bcv_pkg::KIND_DONE, 0, 0, 1'b1, 1'b1));
    write_vcount(32);                    // store overflow: more edges than the store holds
    for (int k = 0; k < 70; k++)
      send_edge('{end_a: 5'(k % 32), end_b: 5'((k + 1) % 32), last_edge: 1'(k == 69)});
    // sender holds off until all results came
    check_done(mk(bcv_pkg::KIND_DONE, 0, 0, 1'b1, 1'b1));

    // Random part in three idle phases.
    sent = 0;
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 59 : 0;
      snk_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 24 : 0;
      while (sent < 107 * (ph + 1)) begin
        nv = ($urandom_range(9) == 0) ? 32 : $urandom_range(10, 2);
        n = $urandom_range(14, 1);
        if ($urandom_range(3) == 0) write_vcount(nv[bcv_pkg::VCNT_W-1:0]);
        random_graph(nv, n);
        sent += n;
      end
    end
    drain();

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/bcv_pkg.sv
hdl/bcv_ram.sv
hdl/bcv_ctrl.sv
hdl/bcv_dpath.sv
hdl/bridge_and_cut_vertex_finder.sv
verif/tb.sv
